[design/sse_pkg.sv]
package sse_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int POWER_BITS  = 32;
  localparam int DIV_BITS    = 24;
  localparam int CFG_DATA_BITS  = 11;
  localparam int CFG_INDEX_BITS = 2;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_VECTOR_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PILOT_SPACING = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DC_NULL_WIDTH = 2'd2;

  localparam logic [POWER_BITS-1:0] POWER_ONE = 32'h4000_0000;
  localparam logic [17:0] ALPHA_W    = 18'd167772;
  localparam logic [23:0] BETA_W     = 24'd16609444;
  localparam logic [23:0] RESULT_MAX = 24'h7F_FFFF;
  localparam logic [23:0] RATIO_ONE  = 24'd65536;
  // largest quotient that stays in range after subtracting one
  localparam logic [23:0] QUOT_MAX   = 24'd8454143;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] ref_re;
    logic signed [SAMPLE_BITS-1:0] ref_im;
    logic signed [SAMPLE_BITS-1:0] num_re;
    logic signed [SAMPLE_BITS-1:0] num_im;
  } sse_in_t;

  typedef struct packed {
    logic signed [23:0] sinr_estimate;
    logic [9:0]         subcarrier_index;
  } sse_out_t;

  typedef struct packed {
    logic                  start;
    logic [4:0]            steps;
    logic [POWER_BITS-1:0] rem0;
    logic [DIV_BITS-1:0]   bits;
    logic [POWER_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIV_BITS-1:0]   quotient;
    logic [POWER_BITS-1:0] remainder;
  } div_rsp_t;

endpackage

[design/sse_power_mem.sv]
module sse_power_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/sse_divider.sv]
module sse_divider (
  input  logic            clk,
  input  logic            rst,
  input  sse_pkg::div_req_t req,
  output sse_pkg::div_rsp_t rsp
);
  import sse_pkg::*;

  logic                  busy;
  logic [4:0]            cnt;
  logic [POWER_BITS-1:0] rem;
  logic [DIV_BITS-1:0]   shreg;
  logic [DIV_BITS-1:0]   quot;
  logic                  done;
  logic [POWER_BITS:0]   trial;
  logic                  ge;

  // restoring division, one quotient bit a cycle
  assign trial = {rem, shreg[DIV_BITS-1]};
  assign ge    = trial >= {1'b0, req.divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        cnt   <= req.steps;
        rem   <= req.rem0;
        shreg <= req.bits;
        quot  <= '0;
      end else if (busy) begin
        rem   <= ge ? POWER_BITS'(trial - {1'b0, req.divisor}) : trial[POWER_BITS-1:0];
        shreg <= {shreg[DIV_BITS-2:0], 1'b0};
        quot  <= {quot[DIV_BITS-2:0], ge};
        cnt   <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quot;
  assign rsp.remainder = rem;

endmodule

[design/subcarrier_sinr_estimator.sv]
// Per-subcarrier SINR estimator. Each item carries one subcarrier: a reference
// sample and a second-stream sample, both Q1.15. Position wraps at
// vector_length; pilot positions are dropped without touching state, every
// other position updates two smoothed powers (Q2.30, weights 0.01 new and 0.99
// old) held in one on-chip memory and emits num_power/ref_power - 1 in Q8.16,
// saturating high. After reset the block runs a clearing pass over all
// MAX_SUBCARRIERS entries that sets every power to 1.0 and holds in_stall high
// meanwhile. Items are handled one at a time: a pilot is settled by the serial
// modulo for the pilot test; a data item then goes on to the read-modify-write
// of the power memory and the 24-step serial divider for the ratio. A finished
// result waits in the output register while the next item is taken.
module subcarrier_sinr_estimator #(
  parameter int MAX_SUBCARRIERS = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  sse_pkg::sse_in_t                      in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output sse_pkg::sse_out_t                     out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sse_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [sse_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  import sse_pkg::*;

  localparam int PW = $clog2(MAX_SUBCARRIERS);
  localparam int LW = PW + 1;
  localparam int SB = SAMPLE_BITS;
  localparam int FRAC = 2 * (SB - 1);
  localparam int SHR = (FRAC > 30) ? FRAC - 30 : 0;
  localparam int SHL = (FRAC < 30) ? 30 - FRAC : 0;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MOD   = 4'd2;
  localparam logic [3:0] S_SQ    = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_SUM   = 4'd5;
  localparam logic [3:0] S_WR    = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state;

  // configuration registers
  logic [10:0] vector_length;
  logic [6:0]  pilot_spacing;
  logic [3:0]  dc_null_width;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= 11'd1024;
      pilot_spacing <= 7'd8;
      dc_null_width <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_VECTOR_LENGTH: vector_length <= cfg_data;
        REG_PILOT_SPACING: pilot_spacing <= cfg_data[6:0];
        REG_DC_NULL_WIDTH: dc_null_width <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // effective length clamped to 2..MAX_SUBCARRIERS
  logic [31:0]   vl32;
  logic [LW-1:0] len;
  logic [PW-1:0] position;
  logic [PW-1:0] pos_eff;
  logic [LW-1:0] pos_inc;
  logic [6:0]    spacing;

  always_comb begin
    vl32 = 32'(vector_length);
    if (vl32 < 32'd2) begin
      len = LW'(2);
    end else if (vl32 > 32'(MAX_SUBCARRIERS)) begin
      len = LW'(MAX_SUBCARRIERS);
    end else begin
      len = LW'(vl32);
    end
    pos_eff = ({1'b0, position} >= len) ? '0 : position;
    pos_inc = {1'b0, pos_eff} + LW'(1);
    spacing = (pilot_spacing == 7'd0) ? 7'd1 : pilot_spacing;
  end

  wire accept = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  // item registers
  sse_in_t        item;
  logic [PW-1:0]  item_pos;
  logic           item_low;
  logic [PW-1:0]  clr_addr;

  // pilot test on the serial remainder
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic [6:0] residue;
  logic [2:0] half_dc;
  logic       pilot;

  always_comb begin
    residue = div_rsp.remainder[6:0];
    half_dc = dc_null_width[3:1];
    if (item_low) begin
      pilot = ({3'b0, residue} == (10'd4 + 10'(half_dc)));
    end else begin
      pilot = (half_dc <= 3'd4) && (residue == 7'(3'd4 - half_dc));
    end
  end

  // power arithmetic
  logic [2*SB-1:0] sq_ref_re, sq_ref_im, sq_num_re, sq_num_im;
  logic [63:0]     p64_ref, p64_num;
  logic [POWER_BITS-1:0] p_ref, p_num;
  logic [49:0]     pa_ref, pa_num;
  logic [55:0]     pb_ref, pb_num;
  logic [56:0]     acc_ref, acc_num;
  logic [32:0]     sh_ref, sh_num;
  logic [POWER_BITS-1:0] rp, np;
  logic [POWER_BITS-1:0] rp_new, np_new;
  logic [63:0]     mem_rdata;
  logic            ovf;

  always_comb begin
    p64_ref = 64'(sq_ref_re) + 64'(sq_ref_im);
    p64_num = 64'(sq_num_re) + 64'(sq_num_im);
    p_ref   = POWER_BITS'((p64_ref >> SHR) << SHL);
    p_num   = POWER_BITS'((p64_num >> SHR) << SHL);
    acc_ref = 57'(pa_ref) + 57'(pb_ref) + 57'(24'h80_0000);
    acc_num = 57'(pa_num) + 57'(pb_num) + 57'(24'h80_0000);
    sh_ref  = acc_ref[56:24];
    sh_num  = acc_num[56:24];
    rp_new  = sh_ref[32] ? '1 : sh_ref[31:0];
    np_new  = sh_num[32] ? '1 : sh_num[31:0];
  end

  // memory control
  logic          mem_we, mem_re;
  logic [PW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;

  always_comb begin
    mem_we    = (state == S_CLEAR) || (state == S_WR);
    mem_waddr = (state == S_CLEAR) ? clr_addr : item_pos;
    mem_wdata = (state == S_CLEAR) ? {POWER_ONE, POWER_ONE} : {np, rp};
    mem_re    = (state == S_MOD) && div_rsp.done && !pilot;
  end

  sse_power_mem #(
    .DEPTH (MAX_SUBCARRIERS),
    .AW    (PW),
    .DW    (64)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (item_pos),
    .rdata (mem_rdata)
  );

  // divider requests: modulo at accept, ratio at write-back
  always_comb begin
    div_req = '0;
    if (accept) begin
      div_req.start   = 1'b1;
      div_req.steps   = 5'(PW);
      div_req.rem0    = '0;
      div_req.bits    = {pos_eff, {(DIV_BITS-PW){1'b0}}};
      div_req.divisor = POWER_BITS'(spacing);
    end else if (state == S_WR) begin
      div_req.start   = 1'b1;
      div_req.steps   = 5'(DIV_BITS);
      div_req.rem0    = {8'b0, np[31:8]};
      div_req.bits    = {np[7:0], 16'b0};
      div_req.divisor = rp;
    end else begin
      div_req.divisor = (state == S_DIV) ? rp : POWER_BITS'(spacing);
    end
  end

  sse_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // sequencer
  logic [23:0] quot_adj;
  logic        sat;
  assign sat      = ovf || (div_rsp.quotient > QUOT_MAX);
  assign quot_adj = div_rsp.quotient - RATIO_ONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      position  <= '0;
      out_valid <= 1'b0;
    end else begin
      // the output step reloads the register itself
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + PW'(1);
          if (clr_addr == PW'(MAX_SUBCARRIERS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            item     <= in_data;
            item_pos <= pos_eff;
            item_low <= ({1'b0, pos_eff} < (len >> 1));
            position <= (pos_inc >= len) ? '0 : pos_inc[PW-1:0];
            state    <= S_MOD;
          end
        end
        S_MOD: begin
          if (div_rsp.done) begin
            state <= pilot ? S_IDLE : S_SQ;
          end
        end
        S_SQ: begin
          sq_ref_re <= (2*SB)'($signed(item.ref_re) * $signed(item.ref_re));
          sq_ref_im <= (2*SB)'($signed(item.ref_im) * $signed(item.ref_im));
          sq_num_re <= (2*SB)'($signed(item.num_re) * $signed(item.num_re));
          sq_num_im <= (2*SB)'($signed(item.num_im) * $signed(item.num_im));
          state     <= S_MUL;
        end
        S_MUL: begin
          pa_ref <= 50'(ALPHA_W * p_ref);
          pa_num <= 50'(ALPHA_W * p_num);
          pb_ref <= 56'(BETA_W * mem_rdata[31:0]);
          pb_num <= 56'(BETA_W * mem_rdata[63:32]);
          state  <= S_SUM;
        end
        S_SUM: begin
          rp    <= rp_new;
          np    <= np_new;
          state <= S_WR;
        end
        S_WR: begin
          ovf   <= ({8'b0, np[31:8]} >= rp);
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid                 <= 1'b1;
            out_data.sinr_estimate    <= sat ? RESULT_MAX : quot_adj;
            out_data.subcarrier_index <= 10'(item_pos);
            state                     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result appears only out of the output step
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result without output step");

  // the power memory is written only by the clearing pass or write-back
  a_mem_write: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLEAR || state == S_WR))
    else $error("unexpected power memory write");

  // divider finishes only while the sequencer waits on it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_MOD || state == S_DIV))
    else $error("divider result lost");

endmodule
